### hw/rtl/page_framebuffer_refresh_engine_defines.svh
// Assertion macros shared by the frame buffer refresh engine RTL.
`ifndef PAGE_FRAMEBUFFER_REFRESH_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_REFRESH_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define PFRE_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);
`define PFRE_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define PFRE_ASSERT_ALWAYS(lbl, ck, rn, cond, msg)
`define PFRE_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`endif
`endif

### hw/rtl/pfre_pkg.sv
// Types, constants and codes of the page frame buffer refresh engine.
package pfre_pkg;

  localparam int SCREEN_WIDTH_DEF = 128;
  localparam int PAGE_COUNT_DEF   = 8;
  localparam int COL_W_MAX        = 8;   // SCREEN_WIDTH <= 256
  localparam int PAGE_W_MAX       = 4;   // PAGE_COUNT <= 16
  localparam int CMD_DEPTH        = 4;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BIT_LEFT      = 8'h80;

  // position of the refresh stream within one page
  localparam logic [2:0] PH_PAGE_CTRL = 3'd0;
  localparam logic [2:0] PH_PAGE_CMD  = 3'd1;
  localparam logic [2:0] PH_LO_CTRL   = 3'd2;
  localparam logic [2:0] PH_LO_CMD    = 3'd3;
  localparam logic [2:0] PH_HI_CTRL   = 3'd4;
  localparam logic [2:0] PH_HI_CMD    = 3'd5;
  localparam logic [2:0] PH_DATA_CTRL = 3'd6;
  localparam logic [2:0] PH_DATA      = 3'd7;

  typedef enum logic [1:0] {
    REQ_PIXEL,
    REQ_BITMAP,
    REQ_CLEAR,
    REQ_FETCH
  } req_kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               color;
    logic [7:0]         pattern;
    logic [3:0]         bit_count;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       starts_transfer;
    logic       ends_transfer;
    logic       frame_done;
  } out_t;

  // classified request between front and back
  typedef struct packed {
    req_kind_t             kind;
    logic [PAGE_W_MAX-1:0] page;
    logic [COL_W_MAX-1:0]  col;
    logic [2:0]            row_bit;
    logic                  color;
    logic [7:0]            hits;    // bit i: pixel at col+i is on screen and to be written
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BIT,
    BK_WR,
    BK_CLEAR,
    BK_FETCH,
    BK_FETCH_OUT
  } back_state_t;

endpackage

### hw/rtl/page_framebuffer_refresh_engine.sv
// Fetch: BK_IDLE takes a fetch once the result slot is free; BK_FETCH loads the result register,
// or for a page data byte reads the store so that BK_FETCH_OUT loads it.
// Draws: BK_BIT reads each pixel or bitmap bit and BK_WR writes back each hit; a clear writes
// every store byte in turn. A new command is taken only in BK_IDLE.
// Reset: synchronous on rst_n low; after release a clearing pass zeroes all
// SCREEN_WIDTH*PAGE_COUNT store bytes while in_full stays high.
module page_framebuffer_refresh_engine #(
  parameter int SCREEN_WIDTH = pfre_pkg::SCREEN_WIDTH_DEF,
  parameter int PAGE_COUNT   = pfre_pkg::PAGE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  pfre_pkg::in_t  in_data,
  input  logic           out_pop,
  output logic           out_empty,
  output pfre_pkg::out_t out_data
);

  pfre_pkg::cmd_t push_cmd, head_cmd;
  logic           cmd_push, cmd_pop, fifo_full, fifo_empty, init_busy;

  pfre_front #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_front (
    .in_data  (in_data),
    .in_push  (in_push),
    .in_full  (in_full),
    .fifo_full(fifo_full),
    .init_busy(init_busy),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  pfre_cmd_fifo #(
    .DEPTH(pfre_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .din  (push_cmd),
    .full (fifo_full),
    .pop  (cmd_pop),
    .dout (head_cmd),
    .empty(fifo_empty)
  );

  pfre_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(fifo_empty),
    .cmd      (head_cmd),
    .cmd_pop  (cmd_pop),
    .init_busy(init_busy),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

endmodule

### hw/rtl/pfre_cmd_fifo.sv
// Short command queue between the front classifier and the back sequencer.
`include "page_framebuffer_refresh_engine_defines.svh"

module pfre_cmd_fifo #(
  parameter int DEPTH = pfre_pkg::CMD_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pfre_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output pfre_pkg::cmd_t  dout,
  output logic            empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pfre_pkg::cmd_t   q_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (IDX_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

  `PFRE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= (IDX_W+1)'(DEPTH), "queue overfilled")
  `PFRE_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
  `PFRE_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full, "push into full queue")

endmodule

### hw/rtl/pfre_front.sv
// Front end: accepts requests, clips pixels and builds queue commands.
module pfre_front #(
  parameter int SCREEN_WIDTH = pfre_pkg::SCREEN_WIDTH_DEF,
  parameter int PAGE_COUNT   = pfre_pkg::PAGE_COUNT_DEF
) (
  input  pfre_pkg::in_t   in_data,
  input  logic            in_push,
  output logic            in_full,
  input  logic            fifo_full,
  input  logic            init_busy,
  output logic            cmd_push,
  output pfre_pkg::cmd_t  cmd
);

  localparam int ROWS = PAGE_COUNT * 8;

  assign in_full  = fifo_full || init_busy;
  assign cmd_push = in_push && !in_full;

  always_comb begin
    logic              row_ok;
    logic [3:0]        cnt;
    logic [16:0]       c;
    logic [7:0]        col_ok;
    pfre_pkg::req_kind_t kind;
    kind   = pfre_pkg::req_kind_t'(in_data.req_type);
    row_ok = !in_data.y[15] && (in_data.y[14:0] < 15'(ROWS));
    cnt    = (in_data.bit_count > 4'd8) ? 4'd8 : in_data.bit_count;
    // column of bit i is x+i, computed one bit wider so it never wraps
    for (int i = 0; i < 8; i++) begin
      c = {in_data.x[15], in_data.x} + 17'(i);
      col_ok[i] = !c[16] && (c[15:0] < 16'(SCREEN_WIDTH));
    end

    cmd.kind    = kind;
    cmd.page    = in_data.y[6:3];
    cmd.col     = in_data.x[7:0];
    cmd.row_bit = in_data.y[2:0];
    cmd.color   = 1'b1;
    cmd.hits    = '0;
    case (kind)
      pfre_pkg::REQ_PIXEL: begin
        cmd.color = in_data.color;
        cmd.hits  = {7'b0, row_ok && col_ok[0]};
      end
      pfre_pkg::REQ_BITMAP: begin
        for (int i = 0; i < 8; i++) begin
          cmd.hits[i] = row_ok && col_ok[i] && (4'(i) < cnt) &&
                        ((in_data.pattern & (pfre_pkg::BIT_LEFT >> i)) != 8'h00);
        end
      end
      default: begin
        cmd.hits = '0;
      end
    endcase
  end

endmodule

### hw/rtl/pfre_back.sv
// Back end: frame store, read-modify-write sequencer and refresh stream.
`include "page_framebuffer_refresh_engine_defines.svh"

module pfre_back #(
  parameter int SCREEN_WIDTH = pfre_pkg::SCREEN_WIDTH_DEF,
  parameter int PAGE_COUNT   = pfre_pkg::PAGE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_empty,
  input  pfre_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            init_busy,
  input  logic            out_pop,
  output logic            out_empty,
  output pfre_pkg::out_t  out_data
);

  localparam int DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [ADDR_W-1:0] W_A = ADDR_W'(SCREEN_WIDTH);

  logic [7:0] frame_store_r [DEPTH];
  logic [7:0] rd_data_r;

  pfre_pkg::back_state_t state_r, state_nxt;
  pfre_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [7:0]            hits_r, hits_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic                  init_r, init_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic [PG_W-1:0]       page_r, page_nxt;
  logic [COL_W-1:0]      offset_r, offset_nxt;
  logic                  out_valid_r, out_valid_nxt;
  pfre_pkg::out_t        out_data_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data;
  logic              out_load;
  pfre_pkg::out_t    out_new;
  logic [ADDR_W-1:0] bit_addr, fetch_addr;
  logic [COL_W-1:0]  bit_col;
  logic [7:0]        mask;

  assign bit_col    = COL_W'(cmd_r.col) + COL_W'(idx_r);
  assign bit_addr   = W_A * ADDR_W'(cmd_r.page) + ADDR_W'(bit_col);
  assign fetch_addr = W_A * ADDR_W'(page_r) + ADDR_W'(offset_r);
  assign mask       = 8'b1 << cmd_r.row_bit;

  assign init_busy = init_r;
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    hits_nxt   = hits_r;
    idx_nxt    = idx_r;
    clr_nxt    = clr_r;
    init_nxt   = init_r;
    phase_nxt  = phase_r;
    page_nxt   = page_r;
    offset_nxt = offset_r;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = bit_addr;
    wr_data    = cmd_r.color ? (rd_data_r | mask) : (rd_data_r & ~mask);
    rd_addr    = bit_addr;
    out_load   = 1'b0;
    out_new    = '0;

    case (state_r)
      pfre_pkg::BK_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = 8'h00;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          clr_nxt   = '0;
          init_nxt  = 1'b0;
          state_nxt = pfre_pkg::BK_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      pfre_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.kind)
            pfre_pkg::REQ_PIXEL, pfre_pkg::REQ_BITMAP: begin
              cmd_pop   = 1'b1;
              cmd_nxt   = cmd;
              hits_nxt  = cmd.hits;
              idx_nxt   = '0;
              state_nxt = pfre_pkg::BK_BIT;
            end
            pfre_pkg::REQ_CLEAR: begin
              cmd_pop   = 1'b1;
              clr_nxt   = '0;
              state_nxt = pfre_pkg::BK_CLEAR;
            end
            pfre_pkg::REQ_FETCH: begin
              // only start once the result slot is free
              if (!out_valid_r) begin
                cmd_pop   = 1'b1;
                state_nxt = pfre_pkg::BK_FETCH;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      pfre_pkg::BK_BIT: begin
        // read issued here, data lands in rd_data_r for BK_WR
        if (hits_r == 8'h00) begin
          state_nxt = pfre_pkg::BK_IDLE;
        end else if (hits_r[idx_r]) begin
          state_nxt = pfre_pkg::BK_WR;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      pfre_pkg::BK_WR: begin
        wr_en            = 1'b1;
        hits_nxt[idx_r]  = 1'b0;
        idx_nxt          = idx_r + 1'b1;
        state_nxt        = pfre_pkg::BK_BIT;
      end
      pfre_pkg::BK_FETCH: begin
        if (phase_r == pfre_pkg::PH_DATA) begin
          rd_addr   = fetch_addr;
          state_nxt = pfre_pkg::BK_FETCH_OUT;
        end else begin
          out_load  = 1'b1;
          phase_nxt = phase_r + 3'd1;
          state_nxt = pfre_pkg::BK_IDLE;
          case (phase_r)
            pfre_pkg::PH_PAGE_CTRL, pfre_pkg::PH_LO_CTRL, pfre_pkg::PH_HI_CTRL: begin
              out_new.out_byte        = pfre_pkg::BYTE_ZERO;
              out_new.starts_transfer = 1'b1;
            end
            pfre_pkg::PH_PAGE_CMD: begin
              out_new.out_byte      = pfre_pkg::CMD_PAGE_BASE + 8'(page_r);
              out_new.ends_transfer = 1'b1;
            end
            pfre_pkg::PH_LO_CMD: begin
              out_new.out_byte      = pfre_pkg::BYTE_ZERO;
              out_new.ends_transfer = 1'b1;
            end
            pfre_pkg::PH_HI_CMD: begin
              out_new.out_byte      = pfre_pkg::CMD_COL_HI;
              out_new.ends_transfer = 1'b1;
            end
            pfre_pkg::PH_DATA_CTRL: begin
              out_new.out_byte        = pfre_pkg::CTRL_DATA;
              out_new.starts_transfer = 1'b1;
              offset_nxt              = '0;
            end
            default: begin
              out_new = '0;
            end
          endcase
        end
      end
      pfre_pkg::BK_FETCH_OUT: begin
        out_load         = 1'b1;
        out_new.out_byte = rd_data_r;
        state_nxt        = pfre_pkg::BK_IDLE;
        if (offset_r == COL_W'(SCREEN_WIDTH - 1)) begin
          out_new.ends_transfer = 1'b1;
          phase_nxt             = pfre_pkg::PH_PAGE_CTRL;
          offset_nxt            = '0;
          if (page_r == PG_W'(PAGE_COUNT - 1)) begin
            out_new.frame_done = 1'b1;
            page_nxt           = '0;
          end else begin
            page_nxt = page_r + 1'b1;
          end
        end else begin
          offset_nxt = offset_r + 1'b1;
        end
      end
      default: begin
        state_nxt = pfre_pkg::BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfre_pkg::BK_CLEAR;
      hits_r      <= '0;
      idx_r       <= '0;
      clr_r       <= '0;
      init_r      <= 1'b1;
      phase_r     <= pfre_pkg::PH_PAGE_CTRL;
      page_r      <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hits_r      <= hits_nxt;
      idx_r       <= idx_nxt;
      clr_r       <= clr_nxt;
      init_r      <= init_nxt;
      phase_r     <= phase_nxt;
      page_r      <= page_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (out_load) begin
      out_data_r <= out_new;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= frame_store_r[rd_addr];
    if (wr_en) begin
      frame_store_r[wr_addr] <= wr_data;
    end
  end

  `PFRE_ASSERT_IMPL(a_out_no_overwrite, clk, rst_n, out_load, !out_valid_r, "result overwritten")
  `PFRE_ASSERT_IMPL(a_init_zero, clk, rst_n, init_r && wr_en, wr_data == 8'h00, "init sweep wrote data")
  `PFRE_ASSERT_IMPL(a_wr_has_hit, clk, rst_n, state_r == pfre_pkg::BK_WR, hits_r[idx_r], "write without hit")
  `PFRE_ASSERT_IMPL(a_data_read, clk, rst_n, state_r == pfre_pkg::BK_FETCH_OUT, (phase_r == pfre_pkg::PH_DATA) && ($past(state_r) == pfre_pkg::BK_FETCH), "data byte out of phase")

endmodule

### sim/tb_top.sv
// Self-checking testbench for the page frame buffer refresh engine: draws, clears, refresh fetches.
`timescale 1ns / 100ps

module tb_top;

  localparam int SCR_W          = pfre_pkg::SCREEN_WIDTH_DEF;
  localparam int PAGES          = pfre_pkg::PAGE_COUNT_DEF;
  localparam int ROWS           = PAGES * 8;
  localparam int N_RANDOM       = 720;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 16;

  class refresh_checker;
    bit [7:0]         shadow_store [SCR_W*PAGES];
    logic [2:0]       stream_phase;
    int               stream_page;
    int               stream_col;
    pfre_pkg::out_t   fetch_q [$];
    int               errors;

    function new();
      clear_store();
      stream_phase = pfre_pkg::PH_PAGE_CTRL;
      stream_page  = 0;
      stream_col   = 0;
      errors       = 0;
    endfunction

    function void clear_store();
      foreach (shadow_store[i]) shadow_store[i] = '0;
    endfunction

    function void put_pixel(int col, int row, bit on);
      int addr;
      if (col < 0 || col >= SCR_W || row < 0 || row >= ROWS) return;
      addr = (row / 8) * SCR_W + col;
      shadow_store[addr][row % 8] = on;
    endfunction

    // next byte of the endless refresh stream, advancing the stream position
    function pfre_pkg::out_t next_fetch();
      pfre_pkg::out_t r;
      r = '0;
      case (stream_phase)
        pfre_pkg::PH_PAGE_CTRL, pfre_pkg::PH_LO_CTRL, pfre_pkg::PH_HI_CTRL: begin
          r.out_byte        = pfre_pkg::BYTE_ZERO;
          r.starts_transfer = 1'b1;
          stream_phase      = stream_phase + 3'd1;
        end
        pfre_pkg::PH_PAGE_CMD: begin
          r.out_byte      = pfre_pkg::CMD_PAGE_BASE + 8'(stream_page);
          r.ends_transfer = 1'b1;
          stream_phase    = stream_phase + 3'd1;
        end
        pfre_pkg::PH_LO_CMD: begin
          r.out_byte      = pfre_pkg::BYTE_ZERO;
          r.ends_transfer = 1'b1;
          stream_phase    = stream_phase + 3'd1;
        end
        pfre_pkg::PH_HI_CMD: begin
          r.out_byte      = pfre_pkg::CMD_COL_HI;
          r.ends_transfer = 1'b1;
          stream_phase    = stream_phase + 3'd1;
        end
        pfre_pkg::PH_DATA_CTRL: begin
          r.out_byte        = pfre_pkg::CTRL_DATA;
          r.starts_transfer = 1'b1;
          stream_phase      = pfre_pkg::PH_DATA;
          stream_col        = 0;
        end
        default: begin
          r.out_byte = shadow_store[stream_page*SCR_W + stream_col];
          stream_col++;
          if (stream_col >= SCR_W) begin
            r.ends_transfer = 1'b1;
            if (stream_page + 1 >= PAGES) begin
              r.frame_done = 1'b1;
              stream_page  = 0;
            end else begin
              stream_page++;
            end
            stream_phase = pfre_pkg::PH_PAGE_CTRL;
            stream_col   = 0;
          end
        end
      endcase
      return r;
    endfunction

    // called once per accepted input transfer
    function void apply_request(pfre_pkg::in_t req);
      int xs;
      int ys;
      int n;
      xs = $signed(req.x);
      ys = $signed(req.y);
      case (req.req_type)
        pfre_pkg::REQ_PIXEL:  put_pixel(xs, ys, req.color);
        pfre_pkg::REQ_BITMAP: begin
          n = (req.bit_count > 4'd8) ? 8 : int'(req.bit_count);
          for (int i = 0; i < n; i++)
            if (req.pattern[7-i]) put_pixel(xs + i, ys, 1'b1);
        end
        pfre_pkg::REQ_CLEAR:  clear_store();
        default:              fetch_q.push_back(next_fetch());
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(pfre_pkg::out_t got);
      pfre_pkg::out_t want;
      if (fetch_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h st=%0b en=%0b fd=%0b",
                                  got.out_byte, got.starts_transfer, got.ends_transfer,
                                  got.frame_done));
        return;
      end
      want = fetch_q.pop_front();
      if (got.out_byte !== want.out_byte || got.starts_transfer !== want.starts_transfer ||
          got.ends_transfer !== want.ends_transfer || got.frame_done !== want.frame_done)
        report_mismatch($sformatf("byte %02h/%02h st %0b/%0b en %0b/%0b fd %0b/%0b (got/exp)",
                                  got.out_byte, want.out_byte,
                                  got.starts_transfer, want.starts_transfer,
                                  got.ends_transfer, want.ends_transfer,
                                  got.frame_done, want.frame_done));
    endtask

    function int pending();
      return fetch_q.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_push;
  logic           in_full;
  pfre_pkg::in_t  in_data;
  logic           out_pop;
  logic           out_empty;
  pfre_pkg::out_t out_data;

  refresh_checker sb;
  int idle_cycles;
  int pop_hold;
  bit pop_calm;

  page_framebuffer_refresh_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // mostly on screen, some just past the edges, some anywhere in 16 bits
  function automatic logic [15:0] rand_coord(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, span - 1));
    if (r < 85) return 16'(int'($urandom_range(0, span + 15)) - 8);
    return 16'($urandom);
  endfunction

  function automatic pfre_pkg::in_t make_req(pfre_pkg::req_kind_t k, int x, int y, bit c,
                                             bit [7:0] p, bit [3:0] n);
    pfre_pkg::in_t r;
    r.req_type  = k;
    r.x         = 16'(x);
    r.y         = 16'(y);
    r.color     = c;
    r.pattern   = p;
    r.bit_count = n;
    return r;
  endfunction

  function automatic pfre_pkg::in_t rand_req();
    pfre_pkg::in_t r;
    int            sel;
    // fields the request kind does not use stay random
    r.x         = 16'($urandom);
    r.y         = 16'($urandom);
    r.color     = 1'($urandom);
    r.pattern   = 8'($urandom);
    r.bit_count = 4'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      r.req_type = pfre_pkg::REQ_FETCH;
    end else if (sel < 88) begin
      r.req_type = pfre_pkg::REQ_PIXEL;
      r.x        = rand_coord(SCR_W);
      r.y        = rand_coord(ROWS);
      r.color    = ($urandom_range(0, 9) < 7);
    end else if (sel < 99) begin
      r.req_type = pfre_pkg::REQ_BITMAP;
      r.x        = rand_coord(SCR_W);
      r.y        = rand_coord(ROWS);
    end else begin
      r.req_type = pfre_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  // caller sits at a rising edge; returns at the edge where the transfer happened
  task automatic push_item(pfre_pkg::in_t item);
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.apply_request(item);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // result side: sample with the pre-edge pop, then pick the next pop
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_hold = 0;
      pop_calm = 1'b0;
    end else begin
      if (out_pop && !out_empty) sb.check_result(out_data);
      if ($urandom_range(0, 299) == 0) pop_calm = !pop_calm;
      if (pop_hold > 0) begin
        pop_hold--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!pop_calm && $urandom_range(0, 99) < 30) pop_hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("page_framebuffer_refresh_engine test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit calm;
    sb          = new();
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_data     = '0;
    out_pop     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corners, off-screen rows and columns, 16-bit extremes, pixel clear
    push_item(make_req(pfre_pkg::REQ_PIXEL, 0, 0, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, SCR_W - 1, ROWS - 1, 1'b1, 8'hFF, 4'd15));
    push_item(make_req(pfre_pkg::REQ_PIXEL, SCR_W - 1, 0, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, 0, ROWS - 1, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, -1, 5, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, SCR_W, 5, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, 5, -1, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, 5, ROWS, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, -32768, 32767, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, 32767, -32768, 1'b1, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_PIXEL, SCR_W - 1, ROWS - 1, 1'b0, 8'h00, 4'd0));
    // bitmap: right and left clipping, oversize count, zero count, empty pattern
    push_item(make_req(pfre_pkg::REQ_BITMAP, SCR_W - 4, 9, 1'b0, 8'hFF, 4'd8));
    push_item(make_req(pfre_pkg::REQ_BITMAP, -3, 0, 1'b0, 8'hFF, 4'd8));
    push_item(make_req(pfre_pkg::REQ_BITMAP, 40, 30, 1'b1, 8'hA5, 4'd15));
    push_item(make_req(pfre_pkg::REQ_BITMAP, 50, 31, 1'b0, 8'hFF, 4'd0));
    push_item(make_req(pfre_pkg::REQ_BITMAP, 60, 40, 1'b0, 8'h00, 4'd8));
    push_item(make_req(pfre_pkg::REQ_BITMAP, 32763, 10, 1'b0, 8'hFF, 4'd8));
    // command phases, data control byte, first data columns
    repeat (9) push_item(make_req(pfre_pkg::REQ_FETCH, 0, 0, 1'b0, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_CLEAR, 0, 0, 1'b0, 8'h00, 4'd0));
    push_item(make_req(pfre_pkg::REQ_FETCH, 0, 0, 1'b0, 8'h00, 4'd0));

    calm = 1'b0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (k == N_RANDOM / 2) begin
        // let the result side drain completely before going on
        in_push <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end else if (!calm) begin
        idle_sender(gap_len());
      end
      push_item(rand_req());
    end
    in_push <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("page_framebuffer_refresh_engine test passed");
    else
      $display("page_framebuffer_refresh_engine test failed");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pfre_pkg.sv
hw/rtl/pfre_cmd_fifo.sv
hw/rtl/pfre_front.sv
hw/rtl/pfre_back.sv
hw/rtl/page_framebuffer_refresh_engine.sv
sim/tb_top.sv
